>>> rtl/cass_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cass_pkg: shared types and constants for the cache-aware server select unit
// Beat layouts, operation and tier codes, configuration indexes and helpers.
// ---------------------------------------------------------------------------
package cass_pkg;

	// Default sizes
	localparam int NUM_SERVERS_DEF      = 8;
	localparam int PORTS_PER_SERVER_DEF = 4;
	localparam int NUM_MODELS_DEF       = 64;

	// Fixed field widths of a beat
	localparam int OP_W     = 2;
	localparam int MODEL_W  = 6;
	localparam int SERVER_W = 3;
	localparam int PORT_W   = 2;
	localparam int IP_W     = 32;
	localparam int PNUM_W   = 16;
	localparam int LOAD_W   = 8;
	localparam int TIER_W   = 3;
	localparam int CFG_IDX_W = 1;

	// Reachable extent of each index field
	localparam int MODEL_SPAN  = 1 << MODEL_W;
	localparam int SERVER_SPAN = 1 << SERVER_W;
	localparam int PORT_SPAN   = 1 << PORT_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SELECT      = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_SLOT  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE_CACHE = 2'd2;

	// Tier codes
	localparam logic [TIER_W-1:0] TIER_CACHED_IDLE = 3'd0;
	localparam logic [TIER_W-1:0] TIER_ANY_IDLE    = 3'd1;
	localparam logic [TIER_W-1:0] TIER_CACHED_BUSY = 3'd2;
	localparam logic [TIER_W-1:0] TIER_LEAST       = 3'd3;
	localparam logic [TIER_W-1:0] TIER_NONE        = 3'd4;
	localparam logic [TIER_W-1:0] TIER_WRITE       = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_THRESHOLD  = 1'd1;

	localparam logic [LOAD_W-1:0] BUSY_THRESHOLD_RST = 8'd2;
	localparam logic [LOAD_W-1:0] SAT_THRESHOLD_RST  = 8'd4;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [MODEL_W-1:0]  model_index;
		logic [SERVER_W-1:0] server_index;
		logic [PORT_W-1:0]   port_index;
		logic [IP_W-1:0]     ip_address;
		logic [PNUM_W-1:0]   port_number;
		logic [LOAD_W-1:0]   load_value;
		logic                flag_value;
	} item_t;

	typedef struct packed {
		logic [TIER_W-1:0] tier;
		logic [IP_W-1:0]   chosen_ip;
		logic [PNUM_W-1:0] chosen_port;
		logic [LOAD_W-1:0] chosen_load;
	} result_t;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [PNUM_W-1:0] pnum;
		logic [LOAD_W-1:0] load;
	} slot_entry_t;

	// Winner of a scan, as seen by the sequencer
	typedef struct packed {
		logic              found;
		logic [TIER_W-1:0] tier;
	} pick_t;

	function automatic int addr_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int min_i(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

endpackage

>>> rtl/cass_slot_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cass_slot_store: worker slot table
// Address, port number and load per slot in a memory with a registered read;
// valid marks in flops cleared by reset.
// ---------------------------------------------------------------------------
module cass_slot_store #(
	parameter int SLOTS = cass_pkg::NUM_SERVERS_DEF * cass_pkg::PORTS_PER_SERVER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [cass_pkg::addr_w(SLOTS)-1:0]   wr_addr,
	input  cass_pkg::slot_entry_t                wr_entry,
	input  logic                                 wr_valid,
	input  logic [cass_pkg::addr_w(SLOTS)-1:0]   rd_addr,
	output cass_pkg::slot_entry_t                rd_entry,
	output logic                                 rd_valid
);
	import cass_pkg::*;

	slot_entry_t      mem_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	slot_entry_t      rd_entry_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		rd_entry_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_valid;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

>>> rtl/cass_cache_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cass_cache_store: per-model bitmap of caching servers
// One row per model in a memory with a registered read; a row never written
// reads as all zero through its row valid flop.
// ---------------------------------------------------------------------------
module cass_cache_store #(
	parameter int ROWS  = cass_pkg::NUM_MODELS_DEF,
	parameter int WIDTH = cass_pkg::NUM_SERVERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [cass_pkg::addr_w(ROWS)-1:0]   wr_addr,
	input  logic [WIDTH-1:0]                    wr_row,
	input  logic [cass_pkg::addr_w(ROWS)-1:0]   rd_addr,
	output logic [WIDTH-1:0]                    rd_row
);
	import cass_pkg::*;

	logic [WIDTH-1:0] mem_q [ROWS];
	logic [ROWS-1:0]  row_valid_q;
	logic [WIDTH-1:0] rd_row_q;
	logic             rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		rd_row_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			rd_hit_q <= row_valid_q[rd_addr];
		end
	end

	// Mask rows never written back to their reset value
	assign rd_row = rd_hit_q ? rd_row_q : '0;

endmodule

>>> rtl/cass_tier_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cass_tier_scan: shared tier tracker
// Takes one slot per step and keeps the first hit of each tier and the
// running least load; reports the winning tier and slot.
// ---------------------------------------------------------------------------
module cass_tier_scan #(
	parameter int SLOTS = cass_pkg::NUM_SERVERS_DEF * cass_pkg::PORTS_PER_SERVER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 clear,
	input  logic                                 step,
	input  logic                                 slot_valid,
	input  logic [cass_pkg::LOAD_W-1:0]          slot_load,
	input  logic                                 slot_cached,
	input  logic [cass_pkg::addr_w(SLOTS)-1:0]   slot_idx,
	input  logic [cass_pkg::LOAD_W-1:0]          busy_thr,
	input  logic [cass_pkg::LOAD_W-1:0]          sat_thr,
	output cass_pkg::pick_t                      pick,
	output logic [cass_pkg::addr_w(SLOTS)-1:0]   pick_idx
);
	import cass_pkg::*;

	localparam int AW = addr_w(SLOTS);

	logic          ci_found_q, ai_found_q, cb_found_q, lm_found_q;
	logic [AW-1:0] ci_idx_q, ai_idx_q, cb_idx_q, lm_idx_q;
	logic [LOAD_W-1:0] min_q;

	logic idle;
	logic hit_ci, hit_ai, hit_cb, hit_lm;

	always_comb begin
		idle   = (slot_load == '0);
		hit_ci = step && slot_valid && slot_cached && idle && !ci_found_q;
		hit_ai = step && slot_valid && idle && !ai_found_q;
		hit_cb = step && slot_valid && slot_cached && (slot_load < busy_thr) && !cb_found_q;
		// Strict compare: the earliest slot keeps a tie
		hit_lm = step && slot_valid && (slot_load < min_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_found_q <= 1'b0;
			ai_found_q <= 1'b0;
			cb_found_q <= 1'b0;
			lm_found_q <= 1'b0;
		end else if (clear) begin
			ci_found_q <= 1'b0;
			ai_found_q <= 1'b0;
			cb_found_q <= 1'b0;
			lm_found_q <= 1'b0;
		end else begin
			if (hit_ci) ci_found_q <= 1'b1;
			if (hit_ai) ai_found_q <= 1'b1;
			if (hit_cb) cb_found_q <= 1'b1;
			if (hit_lm) lm_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			min_q <= sat_thr;
		end else if (hit_lm) begin
			min_q <= slot_load;
		end
		if (hit_ci) ci_idx_q <= slot_idx;
		if (hit_ai) ai_idx_q <= slot_idx;
		if (hit_cb) cb_idx_q <= slot_idx;
		if (hit_lm) lm_idx_q <= slot_idx;
	end

	always_comb begin
		pick.found = 1'b1;
		if (ci_found_q) begin
			pick.tier = TIER_CACHED_IDLE;
			pick_idx  = ci_idx_q;
		end else if (ai_found_q) begin
			pick.tier = TIER_ANY_IDLE;
			pick_idx  = ai_idx_q;
		end else if (cb_found_q) begin
			pick.tier = TIER_CACHED_BUSY;
			pick_idx  = cb_idx_q;
		end else if (lm_found_q) begin
			pick.tier = TIER_LEAST;
			pick_idx  = lm_idx_q;
		end else begin
			pick.found = 1'b0;
			pick.tier  = TIER_NONE;
			pick_idx   = lm_idx_q;
		end
	end

endmodule

>>> rtl/cache_aware_server_select_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cache_aware_server_select_unit: cache-aware worker slot selector
// Slot table and model cache bitmap with a four-tier select scan.
// ---------------------------------------------------------------------------
// Raise start with an item beat while busy is low; the beat is taken at that
// edge. Every beat gives exactly one result beat on result, marked by a
// one-cycle result_valid pulse that cannot be held off: capture it when it
// comes. A slot write is done in the decode state alone; a cache bit write
// adds a state that reads, modifies and writes the model's row; a select
// walks decode, a row read, one slot read per cycle from the slot memory's
// single read port, a drain state for the last read, all four tiers tracked
// in that same pass by one shared tracker, then a pick and a fetch of the
// winner, with the fetch skipped when nothing qualifies.
// The result pulse comes in the same cycle that busy drops, where the next
// beat may already be taken. Write the thresholds through cfg_we only while
// no beat is in flight. Only servers below 8 and ports below 4 can be named
// by a beat, so the slot table holds min(NUM_SERVERS, 8) x
// min(PORTS_PER_SERVER, 4) slots and the bitmap min(NUM_MODELS, 64) rows;
// no clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module cache_aware_server_select_unit #(
	parameter int NUM_SERVERS      = cass_pkg::NUM_SERVERS_DEF,
	parameter int PORTS_PER_SERVER = cass_pkg::PORTS_PER_SERVER_DEF,
	parameter int NUM_MODELS       = cass_pkg::NUM_MODELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  cass_pkg::item_t                   item,
	output logic                              result_valid,
	output cass_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [cass_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cass_pkg::LOAD_W-1:0]       cfg_data
);
	import cass_pkg::*;

	// Reachable geometry
	localparam int SRV_EFF  = min_i(NUM_SERVERS, SERVER_SPAN);
	localparam int PRT_EFF  = min_i(PORTS_PER_SERVER, PORT_SPAN);
	localparam int SLOTS    = SRV_EFF * PRT_EFF;
	localparam int ROWS     = min_i(NUM_MODELS, MODEL_SPAN);
	localparam int SLOT_AW  = addr_w(SLOTS);
	localparam int SRV_AW   = addr_w(SRV_EFF);
	localparam int PRT_AW   = addr_w(PRT_EFF);
	localparam int ROW_AW   = addr_w(ROWS);

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_ROW    = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_PICK   = 3'd5;
	localparam logic [2:0] ST_FETCH  = 3'd6;
	localparam logic [2:0] ST_CMOD   = 3'd7;

	logic [2:0]        state_q;
	item_t             item_q;
	logic [LOAD_W-1:0] busy_thr_q;
	logic [LOAD_W-1:0] sat_thr_q;
	logic [SRV_EFF-1:0] cached_q;
	logic [SLOT_AW-1:0] slot_q;
	logic [SRV_AW-1:0]  server_q;
	logic [PRT_AW-1:0]  port_q;
	logic               vld_s1;
	logic [SRV_AW-1:0]  server_s1;
	logic [SLOT_AW-1:0] slot_s1;
	logic [TIER_W-1:0]  tier_q;
	result_t            result_q;
	logic               result_valid_q;

	logic               server_ok, port_ok, model_ok;
	logic               slot_wr_en;
	logic [SLOT_AW-1:0] slot_wr_addr;
	slot_entry_t        slot_wr_entry;
	logic [SLOT_AW-1:0] slot_rd_addr;
	slot_entry_t        slot_rd_entry;
	logic               slot_rd_valid;
	logic               cache_wr_en;
	logic [ROW_AW-1:0]  cache_addr;
	logic [SRV_EFF-1:0] cache_rd_row;
	logic [SRV_EFF-1:0] cache_wr_row;
	logic [SRV_EFF-1:0] cache_bit;
	logic               scan_clear;
	pick_t              pick;
	logic [SLOT_AW-1:0] pick_idx;

	// Decode of the held beat
	always_comb begin
		server_ok     = int'(item_q.server_index) < SRV_EFF;
		port_ok       = int'(item_q.port_index) < PRT_EFF;
		model_ok      = int'(item_q.model_index) < ROWS;
		slot_wr_addr  = SLOT_AW'(int'(item_q.server_index) * PRT_EFF
		                + int'(item_q.port_index));
		slot_wr_entry = '{ip: item_q.ip_address, pnum: item_q.port_number,
		                  load: item_q.load_value};
		slot_wr_en    = (state_q == ST_DECODE) && (item_q.operation == OP_WRITE_SLOT)
		                && server_ok && port_ok;
		// The pick state reads the winner; every other state walks the scan
		slot_rd_addr  = (state_q == ST_PICK) ? pick_idx : slot_q;
		cache_addr    = ROW_AW'(item_q.model_index);
		cache_bit     = SRV_EFF'(1) << item_q.server_index;
		cache_wr_row  = item_q.flag_value ? (cache_rd_row | cache_bit)
		                                  : (cache_rd_row & ~cache_bit);
		cache_wr_en   = (state_q == ST_CMOD) && model_ok && server_ok;
		scan_clear    = (state_q == ST_ROW);
	end

	cass_slot_store #(
		.SLOTS (SLOTS)
	) u_slot_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (slot_wr_en),
		.wr_addr  (slot_wr_addr),
		.wr_entry (slot_wr_entry),
		.wr_valid (item_q.flag_value),
		.rd_addr  (slot_rd_addr),
		.rd_entry (slot_rd_entry),
		.rd_valid (slot_rd_valid)
	);

	// The row is read continuously at the held model; data is fresh in the
	// cycle after the beat is decoded
	cass_cache_store #(
		.ROWS  (ROWS),
		.WIDTH (SRV_EFF)
	) u_cache_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cache_wr_en),
		.wr_addr (cache_addr),
		.wr_row  (cache_wr_row),
		.rd_addr (cache_addr),
		.rd_row  (cache_rd_row)
	);

	cass_tier_scan #(
		.SLOTS (SLOTS)
	) u_tier_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (scan_clear),
		.step        (vld_s1),
		.slot_valid  (slot_rd_valid),
		.slot_load   (slot_rd_entry.load),
		.slot_cached (cached_q[server_s1]),
		.slot_idx    (slot_s1),
		.busy_thr    (busy_thr_q),
		.sat_thr     (sat_thr_q),
		.pick        (pick),
		.pick_idx    (pick_idx)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_thr_q <= BUSY_THRESHOLD_RST;
			sat_thr_q  <= SAT_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUSY_THRESHOLD: busy_thr_q <= cfg_data;
				CFG_SAT_THRESHOLD:  sat_thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (item_q.operation)
						OP_SELECT: state_q <= ST_ROW;
						OP_WRITE_CACHE: state_q <= ST_CMOD;
						default: begin
							// Slot write lands this cycle; unused code only acks
							state_q        <= ST_IDLE;
							result_valid_q <= 1'b1;
						end
					endcase
				end
				ST_ROW: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (slot_q == SLOT_AW'(SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (pick.found) begin
						state_q <= ST_FETCH;
					end else begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
					end
				end
				ST_FETCH: begin
					state_q        <= ST_IDLE;
					result_valid_q <= 1'b1;
				end
				ST_CMOD: begin
					state_q        <= ST_IDLE;
					result_valid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end

		// Hold the model's cache row for the whole scan
		if (state_q == ST_ROW) begin
			cached_q <= model_ok ? cache_rd_row : '0;
			slot_q   <= '0;
			server_q <= '0;
			port_q   <= '0;
		end

		// Advance the scan in server then port order
		if (state_q == ST_SCAN) begin
			slot_q <= slot_q + 1'b1;
			if (port_q == PRT_AW'(PRT_EFF - 1)) begin
				port_q   <= '0;
				server_q <= server_q + 1'b1;
			end else begin
				port_q <= port_q + 1'b1;
			end
		end
		server_s1 <= server_q;
		slot_s1   <= slot_q;

		case (state_q)
			ST_DECODE: begin
				if (item_q.operation != OP_SELECT && item_q.operation != OP_WRITE_CACHE) begin
					result_q <= '{tier: TIER_WRITE, chosen_ip: '0, chosen_port: '0,
					              chosen_load: '0};
				end
			end
			ST_PICK: begin
				tier_q <= pick.tier;
				if (!pick.found) begin
					result_q <= '{tier: TIER_NONE, chosen_ip: '0, chosen_port: '0,
					              chosen_load: sat_thr_q};
				end
			end
			ST_FETCH: begin
				result_q <= '{tier: tier_q, chosen_ip: slot_rd_entry.ip,
				              chosen_port: slot_rd_entry.pnum,
				              chosen_load: slot_rd_entry.load};
			end
			ST_CMOD: begin
				result_q <= '{tier: TIER_WRITE, chosen_ip: '0, chosen_port: '0,
				              chosen_load: '0};
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> tb/cache_aware_server_select_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cache_aware_server_select_unit_test: self-checking bench for the selector
// Drives slot writes, cache bit writes and selects through the start/busy
// port, mirrors the slot table and cache bitmap in a scoreboard, and checks
// every result beat against the predicted tier, address, port and load.
// ---------------------------------------------------------------------------
module cache_aware_server_select_unit_test;
	import cass_pkg::*;

	localparam int SLOT_COUNT     = NUM_SERVERS_DEF * PORTS_PER_SERVER_DEF;
	localparam int PHASES         = 7;
	localparam int PHASE_ITEMS    = 275;
	localparam int SETTLE_CYCLES  = 40;   // idle cycles after the last result
	localparam int WATCHDOG_LIMIT = 5000;

	// The package names three operations; the fourth code is a no-op.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Threshold plan per random phase; the last phase picks its own values.
	localparam logic [LOAD_W-1:0] BUSY_PLAN [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd2, 8'd0};
	localparam logic [LOAD_W-1:0] SAT_PLAN  [PHASES] = '{8'd0, 8'd255, 8'd3, 8'd0, 8'd255, 8'd4, 8'd0};

	// -----------------------------------------------------------------------
	// Scoreboard: shadow copy of the slot table, cache bitmap and thresholds,
	// plus the queue of result beats still owed by the block.
	// -----------------------------------------------------------------------
	class slot_select_scoreboard;
		logic [IP_W-1:0]            slot_ip [SLOT_COUNT];
		logic [PNUM_W-1:0]          slot_pnum [SLOT_COUNT];
		logic [LOAD_W-1:0]          slot_load [SLOT_COUNT];
		logic                       slot_live [SLOT_COUNT];
		logic [NUM_SERVERS_DEF-1:0] cached_servers [MODEL_SPAN];
		logic [LOAD_W-1:0]          busy_limit;
		logic [LOAD_W-1:0]          sat_limit;
		result_t                    owed_picks [$];
		int                         mismatches;
		int                         tier_hits [6];

		function new();
			for (int s = 0; s < SLOT_COUNT; s++) begin
				slot_ip[s]   = '0;
				slot_pnum[s] = '0;
				slot_load[s] = '0;
				slot_live[s] = 1'b0;
			end
			for (int m = 0; m < MODEL_SPAN; m++)
				cached_servers[m] = '0;
			busy_limit = BUSY_THRESHOLD_RST;
			sat_limit  = SAT_THRESHOLD_RST;
			mismatches = 0;
			foreach (tier_hits[t])
				tier_hits[t] = 0;
		endfunction

		function void set_limits(logic [LOAD_W-1:0] busy_v, logic [LOAD_W-1:0] sat_v);
			busy_limit = busy_v;
			sat_limit  = sat_v;
		endfunction

		function int owed();
			return owed_picks.size();
		endfunction

		// First live slot, on a cached server if asked, with load below limit.
		function int first_below(logic [NUM_SERVERS_DEF-1:0] cached, bit cached_only,
				int limit);
			for (int s = 0; s < SLOT_COUNT; s++) begin
				if (!slot_live[s])
					continue;
				if (cached_only && !cached[s / PORTS_PER_SERVER_DEF])
					continue;
				if (int'(slot_load[s]) < limit)
					return s;
			end
			return -1;
		endfunction

		function result_t pick_for(item_t req);
			result_t                    pick;
			logic [NUM_SERVERS_DEF-1:0] cached;
			int                         s;
			int                         best;
			int                         min_load;
			pick     = '0;
			cached   = cached_servers[req.model_index];
			best     = -1;
			min_load = int'(sat_limit);
			s = first_below(cached, 1'b1, 1);
			if (s >= 0) begin
				pick.tier = TIER_CACHED_IDLE;
			end else begin
				s = first_below(cached, 1'b0, 1);
				if (s >= 0) begin
					pick.tier = TIER_ANY_IDLE;
				end else begin
					s = first_below(cached, 1'b1, int'(busy_limit));
					if (s >= 0) begin
						pick.tier = TIER_CACHED_BUSY;
					end else begin
						// Least loaded under saturation, earliest slot on a tie.
						for (int k = 0; k < SLOT_COUNT; k++) begin
							if (slot_live[k] && int'(slot_load[k]) < min_load) begin
								min_load = int'(slot_load[k]);
								best     = k;
							end
						end
						s = best;
						pick.tier = (best >= 0) ? TIER_LEAST : TIER_NONE;
					end
				end
			end
			if (s >= 0) begin
				pick.chosen_ip   = slot_ip[s];
				pick.chosen_port = slot_pnum[s];
				pick.chosen_load = slot_load[s];
			end else begin
				pick.chosen_load = sat_limit;
			end
			return pick;
		endfunction

		// Apply an accepted beat to the shadow state and queue its result.
		function void note_item(item_t req);
			result_t ack;
			int      s;
			ack      = '0;
			ack.tier = TIER_WRITE;
			s        = int'(req.server_index) * PORTS_PER_SERVER_DEF + int'(req.port_index);
			case (req.operation)
				OP_SELECT: begin
					ack = pick_for(req);
				end
				OP_WRITE_SLOT: begin
					slot_ip[s]   = req.ip_address;
					slot_pnum[s] = req.port_number;
					slot_load[s] = req.load_value;
					slot_live[s] = req.flag_value;
				end
				OP_WRITE_CACHE: begin
					cached_servers[req.model_index][req.server_index] = req.flag_value;
				end
				default: begin
				end
			endcase
			owed_picks.push_back(ack);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed_picks.size() == 0) begin
				$display("%0t: result beat with nothing owed: expected none, got %h",
					$time, got);
				mismatches++;
				return;
			end
			want = owed_picks.pop_front();
			tier_hits[want.tier]++;
			if (got.tier !== want.tier) begin
				$display("%0t: tier expected %0d got %0d", $time, want.tier, got.tier);
				mismatches++;
			end
			if (got.chosen_ip !== want.chosen_ip) begin
				$display("%0t: chosen_ip expected %h got %h", $time, want.chosen_ip,
					got.chosen_ip);
				mismatches++;
			end
			if (got.chosen_port !== want.chosen_port) begin
				$display("%0t: chosen_port expected %h got %h", $time, want.chosen_port,
					got.chosen_port);
				mismatches++;
			end
			if (got.chosen_load !== want.chosen_load) begin
				$display("%0t: chosen_load expected %0d got %0d", $time, want.chosen_load,
					got.chosen_load);
				mismatches++;
			end
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Block under test and its drive signals
	// -----------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	item_t                item      = '0;
	logic                 result_valid;
	result_t              result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BUSY_THRESHOLD;
	logic [LOAD_W-1:0]    cfg_data  = '0;

	slot_select_scoreboard sb = new();
	int                    beats_in    = 0;
	int                    quiet_cycles = 0;

	cache_aware_server_select_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Drive helpers. All of them are entered and left in the time step of a
	// rising edge, so start is assigned at most once per step: hold it high
	// across back-to-back beats, drop it only for a gap or a drain.
	// -----------------------------------------------------------------------
	function automatic item_t make_item(logic [OP_W-1:0] op, int model, int server, int port,
			logic [IP_W-1:0] ip, logic [PNUM_W-1:0] pnum, logic [LOAD_W-1:0] load, bit flag);
		item_t r;
		r.operation    = op;
		r.model_index  = model[MODEL_W-1:0];
		r.server_index = server[SERVER_W-1:0];
		r.port_index   = port[PORT_W-1:0];
		r.ip_address   = ip;
		r.port_number  = pnum;
		r.load_value   = load;
		r.flag_value   = flag;
		return r;
	endfunction

	// Mostly coherent traffic: small loads and a few hot models so that all
	// tiers keep firing; the rest spans the full field ranges.
	function automatic item_t random_request();
		item_t r;
		int    roll;
		r.ip_address   = $urandom;
		r.port_number  = PNUM_W'($urandom);
		r.load_value   = LOAD_W'($urandom);
		r.model_index  = MODEL_W'($urandom);
		r.server_index = SERVER_W'($urandom);
		r.port_index   = PORT_W'($urandom);
		roll = $urandom_range(99);
		if (roll < 45)
			r.operation = OP_SELECT;
		else if (roll < 80)
			r.operation = OP_WRITE_SLOT;
		else if (roll < 96)
			r.operation = OP_WRITE_CACHE;
		else
			r.operation = OP_UNUSED;
		if ($urandom_range(3) != 0)
			r.load_value = LOAD_W'($urandom_range(6));
		if ($urandom_range(4) != 0)
			r.model_index = MODEL_W'($urandom_range(3));
		if (r.operation == OP_WRITE_SLOT)
			r.flag_value = ($urandom_range(99) < 85);
		else if (r.operation == OP_WRITE_CACHE)
			r.flag_value = ($urandom_range(99) < 60);
		else
			r.flag_value = 1'($urandom);
		return r;
	endfunction

	// Offer one beat, with random idle cycles ahead of it, and wait until the
	// block takes it (start high and busy low at an edge).
	task automatic issue(input item_t req, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(req);
		beats_in++;
	endtask

	// Drop start and wait for every owed result, then let the block settle.
	task automatic drain(input int settle);
		start <= 1'b0;
		while (sb.owed() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic program_limits(input logic [LOAD_W-1:0] busy_v,
			input logic [LOAD_W-1:0] sat_v);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BUSY_THRESHOLD;
		cfg_data  <= busy_v;
		@(posedge clk);
		cfg_index <= CFG_SAT_THRESHOLD;
		cfg_data  <= sat_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limits(busy_v, sat_v);
		@(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Result monitor and watchdog. Outputs are sampled at the edge that ends
	// the strobe cycle, before the block's own updates land.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if ((start && !busy) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------
	initial begin
		item_t directed [$];
		logic [LOAD_W-1:0] busy_v;
		logic [LOAD_W-1:0] sat_v;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the tiers at the reset thresholds.
		// Empty table: nothing qualifies.
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, 32'h0, 16'h0, 8'h0, 1'b0));
		// Unused operation with every field at its top value.
		directed.push_back(make_item(OP_UNUSED, 63, 7, 3, '1, '1, '1, 1'b1));
		// Last slot idle and live; first slot written but left invalid.
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 7, 3, '1, '1, 8'd0, 1'b1));
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 0, 0, 32'h1234_5678, 16'h1, 8'd0, 1'b0));
		directed.push_back(make_item(OP_WRITE_CACHE, 63, 7, 0, '0, '0, '0, 1'b1));
		// Cached idle for model 63, plain idle for model 0.
		directed.push_back(make_item(OP_SELECT, 63, 0, 0, '0, '0, '0, 1'b0));
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, '0, '0, '0, 1'b0));
		// Load the last slot: cached-under-busy versus least loaded.
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 7, 3, '1, '1, 8'd1, 1'b1));
		directed.push_back(make_item(OP_SELECT, 63, 0, 0, '0, '0, '0, 1'b0));
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, '0, '0, '0, 1'b0));
		// Equal loads: the earlier slot wins the least-loaded tier.
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 3, 0, 32'ha5a5_a5a5, 16'h8080, 8'd1, 1'b1));
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, '0, '0, '0, 1'b0));
		directed.push_back(make_item(OP_SELECT, 63, 0, 0, '0, '0, '0, 1'b0));
		// Clear the cache bit again.
		directed.push_back(make_item(OP_WRITE_CACHE, 63, 7, 0, '0, '0, '0, 1'b0));
		directed.push_back(make_item(OP_SELECT, 63, 0, 0, '0, '0, '0, 1'b0));
		// Saturate both live slots: no candidate, load reports the threshold.
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 3, 0, 32'ha5a5_a5a5, 16'h8080, 8'd255, 1'b1));
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 7, 3, '1, '1, 8'd4, 1'b1));
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, '0, '0, '0, 1'b0));
		// Validate the first slot, cached for model 0.
		directed.push_back(make_item(OP_WRITE_CACHE, 0, 0, 0, '0, '0, '0, 1'b1));
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 0, 0, 32'h1234_5678, 16'h1, 8'd0, 1'b1));
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, '0, '0, '0, 1'b0));
		directed.push_back(make_item(OP_SELECT, 1, 0, 0, '0, '0, '0, 1'b0));
		// An invalid slot never wins even when idle.
		directed.push_back(make_item(OP_WRITE_SLOT, 0, 0, 0, 32'h1234_5678, 16'h1, 8'd0, 1'b0));
		directed.push_back(make_item(OP_SELECT, 0, 0, 0, '0, '0, '0, 1'b0));

		foreach (directed[i])
			issue(directed[i], 0);

		// Random phases, each at its own threshold setting and idle density.
		for (int p = 0; p < PHASES; p++) begin
			drain(4);
			busy_v = BUSY_PLAN[p];
			sat_v  = SAT_PLAN[p];
			if (p == PHASES - 1) begin
				busy_v = LOAD_W'($urandom_range(6));
				sat_v  = LOAD_W'($urandom_range(8));
			end
			program_limits(busy_v, sat_v);
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue(random_request(), (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 68 : 26));
		end

		drain(SETTLE_CYCLES);

		$display("Ran %0d beats over %0d threshold settings.", beats_in, PHASES + 1);
		$display("Tiers seen: cached idle %0d, idle %0d, cached busy %0d, least %0d, none %0d, ack %0d",
			sb.tier_hits[0], sb.tier_hits[1], sb.tier_hits[2], sb.tier_hits[3],
			sb.tier_hits[4], sb.tier_hits[5]);
		if (sb.owed() != 0)
			$display("%0d result beats never arrived", sb.owed());
		if (sb.mismatches == 0 && sb.owed() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
